FILE: hdl/bbcd_pkg.sv
package bbcd_pkg;

  localparam int unsigned ROW_W           = 16;
  localparam int unsigned NUM_ROWS        = 8;
  localparam int unsigned ROUND_COUNT_DEF = 21;
  localparam int unsigned KEY_REGS        = 4;
  localparam int unsigned CFG_DW          = 64;
  localparam int unsigned CFG_AW          = 5;

  typedef logic [ROW_W-1:0]              row_t;
  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] row_arr_t;
  typedef logic [1:0]                    key_idx_t;

  // key register indexes, byte address is index times 8
  typedef enum logic [1:0] {
    REG_KEY_W0_3   = 2'd0,
    REG_KEY_W4_7   = 2'd1,
    REG_KEY_W8_11  = 2'd2,
    REG_KEY_W12_15 = 2'd3
  } key_reg_t;

  // left rotation of each row in the inverse permutation layer
  localparam int unsigned ROT_AMT [NUM_ROWS] = '{0, 1, 8, 14, 6, 9, 7, 15};

  function automatic row_t rotl(row_t v, int unsigned r);
    logic [2*ROW_W-1:0] tmp;
    tmp = {v, v} << r;
    return tmp[2*ROW_W-1:ROW_W];
  endfunction

  function automatic row_arr_t inv_perm(row_arr_t xi);
    row_arr_t x;
    for (int i = 0; i < NUM_ROWS; i++) begin
      x[i] = rotl(xi[i], ROT_AMT[i]);
    end
    return x;
  endfunction

  // bit-sliced inverse 8-bit s-box, all 16 columns at once
  function automatic row_arr_t inv_sbox(row_arr_t xi);
    row_arr_t x;
    row_t     t0;
    row_t     t1;
    row_t     t2;
    row_t     t3;
    x  = xi;
    t0 = x[7];
    t1 = x[6];
    t2 = x[5];
    t3 = x[7];

    t2   = t2 ^ (x[4] | t1);
    t0   = t0 ^ t2;
    x[3] = x[3] ^ (x[4] | t0);
    x[4] = x[4] ^ t1;
    t1   = t1 ^ x[3];
    t2   = t2 | t1;
    t2   = t2 ^ t0;
    x[4] = x[4] ^ (x[3] & t3);

    x[2] = x[2] ^ t0;
    x[1] = x[1] ^ t2;
    x[0] = x[0] ^ t1;
    x[7] = x[7] ^ x[2];
    x[6] = x[6] ^ x[1];
    x[5] = x[5] ^ x[0];

    x[7] = x[7] ^ (x[3] & x[6]);
    x[3] = x[3] ^ x[7];
    x[6] = x[6] ^ x[4];
    x[5] = x[5] ^ (x[4] | x[3]);
    x[4] = x[4] ^ (x[5] & x[7]);
    x[7] = x[7] ^ (x[5] & x[6]);

    x[2] = x[2] ^ (x[0] | x[1]);
    x[1] = ~x[1];
    x[1] = x[1] ^ (x[2] | x[0]);
    x[0] = x[0] ^ (x[2] & x[1]);
    return x;
  endfunction

endpackage

FILE: hdl/bbcd_round.sv
module bbcd_round #(
  parameter int unsigned ROUND_NUM = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  input  bbcd_pkg::row_arr_t rows_in,
  input  bbcd_pkg::row_arr_t round_key,
  output logic               valid_r,
  output bbcd_pkg::row_arr_t rows_r
);

  bbcd_pkg::row_arr_t mixed;
  bbcd_pkg::row_arr_t rows_nxt;

  always_comb begin
    mixed    = rows_in ^ round_key;
    mixed[0] = mixed[0] ^ bbcd_pkg::ROW_W'(ROUND_NUM);
    rows_nxt = bbcd_pkg::inv_sbox(bbcd_pkg::inv_perm(mixed));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
  end

endmodule

FILE: hdl/bitsliced_block_cipher_decrypt.sv
// 128-bit bit-sliced block decryption under a 256-bit key.
// input channel: a block (rows 0..3 on in_cipher_rows_low, rows 4..7 on
//   in_cipher_rows_high) is taken at each rising edge where start is high
//   and busy is low. busy stays low, so a block can enter every cycle.
// result channel: out_valid is high for exactly one cycle with the plaintext
//   on out_plain_rows_low / out_plain_rows_high; the receiver cannot stall,
//   and none is needed since nothing in the pipe ever waits.
// pipeline: one register stage per round (key add, inverse rotation,
//   inverse s-layer) plus an output stage for the final whitening key add.
//   throughput: one block per cycle, set by the fully unrolled round
//   pipeline.
// configuration: apb-style port, four 64-bit key registers at byte addresses
//   0, 8, 16, 24 (words 0..3, 4..7, 8..11, 12..15). writes land on the edge
//   with psel, penable, pwrite and pready high; pready is always high.
//   keys are read live by every stage, so change them only with the pipe
//   empty.
// reset: rst_n (synchronous, low) clears the keys and all valid bits; blocks
//   in flight are dropped.
module bitsliced_block_cipher_decrypt #(
  parameter int unsigned ROUND_COUNT = bbcd_pkg::ROUND_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [63:0]                   in_cipher_rows_low,
  input  logic [63:0]                   in_cipher_rows_high,
  // result channel
  output logic                          out_valid,
  output logic [63:0]                   out_plain_rows_low,
  output logic [63:0]                   out_plain_rows_high,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbcd_pkg::CFG_AW-1:0]   paddr,
  input  logic [bbcd_pkg::CFG_DW-1:0]   pwdata,
  output logic [bbcd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------
  // key registers
  // ---------------------------------------------------------------
  logic [bbcd_pkg::CFG_DW-1:0] key_r [bbcd_pkg::KEY_REGS];
  bbcd_pkg::key_idx_t          cfg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  // 8-byte register spacing, low address bits ignored
  assign cfg_idx = paddr[bbcd_pkg::CFG_AW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = key_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bbcd_pkg::KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_r[cfg_idx] <= pwdata;
    end
  end

  // even rounds and whitening use words 0..7, odd rounds words 8..15
  bbcd_pkg::row_arr_t key_even;
  bbcd_pkg::row_arr_t key_odd;

  assign key_even = {key_r[bbcd_pkg::REG_KEY_W4_7], key_r[bbcd_pkg::REG_KEY_W0_3]};
  assign key_odd  = {key_r[bbcd_pkg::REG_KEY_W12_15], key_r[bbcd_pkg::REG_KEY_W8_11]};

  // ---------------------------------------------------------------
  // round pipeline: stage k runs round ROUND_COUNT - k
  // ---------------------------------------------------------------
  logic               in_accept;
  logic               stg_valid [ROUND_COUNT+1];
  bbcd_pkg::row_arr_t stg_rows  [ROUND_COUNT+1];

  assign busy         = 1'b0;
  assign in_accept    = start & ~busy;
  assign stg_valid[0] = in_accept;
  assign stg_rows[0]  = {in_cipher_rows_high, in_cipher_rows_low};

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
    localparam int unsigned RND = ROUND_COUNT - k;

    bbcd_round #(
      .ROUND_NUM (RND)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (stg_valid[k]),
      .rows_in   (stg_rows[k]),
      .round_key ((RND % 2 == 1) ? key_odd : key_even),
      .valid_r   (stg_valid[k+1]),
      .rows_r    (stg_rows[k+1])
    );
  end

  // ---------------------------------------------------------------
  // whitening and output register
  // ---------------------------------------------------------------
  logic               out_valid_r;
  bbcd_pkg::row_arr_t out_rows_r;
  bbcd_pkg::row_arr_t out_rows_nxt;

  assign out_rows_nxt = stg_rows[ROUND_COUNT] ^ key_even;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    out_rows_r <= out_rows_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_plain_rows_low  = out_rows_r[3:0];
  assign out_plain_rows_high = out_rows_r[7:4];

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // every accepted item comes out at the end of the pipe
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##(ROUND_COUNT+1) out_valid)
    else $error("accepted item did not emerge after pipe latency");

  // no result without an item accepted earlier at the pipe input
  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, ROUND_COUNT+1))
    else $error("result strobe without matching accepted item");

  // a key write to register 0 lands there; writes elsewhere leave it unchanged
  a_key_write : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx == bbcd_pkg::REG_KEY_W0_3) |=>
      key_r[bbcd_pkg::REG_KEY_W0_3] == $past(pwdata))
    else $error("key write to register 0 not taken");

  a_key_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx != bbcd_pkg::REG_KEY_W0_3) |=>
      $stable(key_r[bbcd_pkg::REG_KEY_W0_3]))
    else $error("key register 0 changed on write to another register");

endmodule

FILE: test/bbcd_plain_checker.sv
`timescale 1ns / 100ps

module bbcd_plain_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [63:0]                 in_cipher_rows_low,
  input  logic [63:0]                 in_cipher_rows_high,
  input  logic                        out_valid,
  input  logic [63:0]                 out_plain_rows_low,
  input  logic [63:0]                 out_plain_rows_high,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbcd_pkg::CFG_AW-1:0] paddr,
  input  logic [bbcd_pkg::CFG_DW-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatch_count,
  output int                          blocks_pending
);

  localparam int unsigned ROUNDS = bbcd_pkg::ROUND_COUNT_DEF;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } plain_t;

  logic [63:0] key_reg [bbcd_pkg::KEY_REGS];
  plain_t      plain_q [$];
  int          errs = 0;

  function automatic bbcd_pkg::row_t key_row(int k);
    return key_reg[k / 4][16 * (k % 4) +: 16];
  endfunction

  function automatic bbcd_pkg::row_t rotl_row(bbcd_pkg::row_t v, int n);
    return (v << n) | (v >> (bbcd_pkg::ROW_W - n));
  endfunction

  // 21 inverse rounds then whitening, all on local copies of the rows
  function automatic plain_t decipher_block(logic [63:0] c_lo, logic [63:0] c_hi);
    bbcd_pkg::row_t x [bbcd_pkg::NUM_ROWS];
    bbcd_pkg::row_t s0;
    bbcd_pkg::row_t s1;
    bbcd_pkg::row_t s2;
    bbcd_pkg::row_t s3;
    plain_t         res;
    int             r;
    int             i;
    for (i = 0; i < 4; i++) begin
      x[i]     = c_lo[16 * i +: 16];
      x[i + 4] = c_hi[16 * i +: 16];
    end
    for (r = ROUNDS; r > 0; r--) begin
      x[0] = x[0] ^ r[bbcd_pkg::ROW_W-1:0];
      // odd rounds take words 8..15, even rounds words 0..7
      for (i = 0; i < bbcd_pkg::NUM_ROWS; i++) begin
        x[i] = x[i] ^ key_row((r % 2 == 1) ? 8 + i : i);
      end
      x[1] = rotl_row(x[1], 1);
      x[2] = rotl_row(x[2], 8);
      x[3] = rotl_row(x[3], 14);
      x[4] = rotl_row(x[4], 6);
      x[5] = rotl_row(x[5], 9);
      x[6] = rotl_row(x[6], 7);
      x[7] = rotl_row(x[7], 15);
      // inverse s-layer over all columns
      s0 = x[7];
      s1 = x[6];
      s2 = x[5];
      s3 = x[7];
      s2   = s2 ^ (x[4] | s1);
      s0   = s0 ^ s2;
      x[3] = x[3] ^ (x[4] | s0);
      x[4] = x[4] ^ s1;
      s1   = s1 ^ x[3];
      s2   = s2 | s1;
      s2   = s2 ^ s0;
      x[4] = x[4] ^ (x[3] & s3);
      x[2] = x[2] ^ s0;
      x[1] = x[1] ^ s2;
      x[0] = x[0] ^ s1;
      x[7] = x[7] ^ x[2];
      x[6] = x[6] ^ x[1];
      x[5] = x[5] ^ x[0];
      x[7] = x[7] ^ (x[3] & x[6]);
      x[3] = x[3] ^ x[7];
      x[6] = x[6] ^ x[4];
      x[5] = x[5] ^ (x[4] | x[3]);
      x[4] = x[4] ^ (x[5] & x[7]);
      x[7] = x[7] ^ (x[5] & x[6]);
      x[2] = x[2] ^ (x[0] | x[1]);
      x[1] = ~x[1];
      x[1] = x[1] ^ (x[2] | x[0]);
      x[0] = x[0] ^ (x[2] & x[1]);
    end
    for (i = 0; i < 4; i++) begin
      res.lo[16 * i +: 16] = x[i] ^ key_row(i);
      res.hi[16 * i +: 16] = x[i + 4] ^ key_row(i + 4);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    plain_t want;
    if (!rst_n) begin
      for (int k = 0; k < bbcd_pkg::KEY_REGS; k++) key_reg[k] = '0;
      plain_q.delete();
    end else begin
      if (out_valid) begin
        if (plain_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: low %h high %h",
                     out_plain_rows_low, out_plain_rows_high);
        end else begin
          want = plain_q.pop_front();
          if (out_plain_rows_low !== want.lo) begin
            errs++;
            if (errs <= 10)
              $display("plain_rows_low mismatch: expected %h got %h",
                       want.lo, out_plain_rows_low);
          end
          if (out_plain_rows_high !== want.hi) begin
            errs++;
            if (errs <= 10)
              $display("plain_rows_high mismatch: expected %h got %h",
                       want.hi, out_plain_rows_high);
          end
        end
      end
      // predict with the keys in force before this edge
      if (start && !busy)
        plain_q.push_back(decipher_block(in_cipher_rows_low, in_cipher_rows_high));
      // low address bits are ignored, as in the block
      if (psel && penable && pwrite && pready)
        key_reg[paddr[bbcd_pkg::CFG_AW-1:3]] = pwdata;
    end
    mismatch_count <= errs;
    blocks_pending <= plain_q.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = bbcd_pkg::ROUND_COUNT_DEF + 6;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [63:0]                 in_cipher_rows_low;
  logic [63:0]                 in_cipher_rows_high;
  logic                        out_valid;
  logic [63:0]                 out_plain_rows_low;
  logic [63:0]                 out_plain_rows_high;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bbcd_pkg::CFG_AW-1:0] paddr;
  logic [bbcd_pkg::CFG_DW-1:0] pwdata;
  logic [bbcd_pkg::CFG_DW-1:0] prdata;
  logic                        pready;
  int                          mismatch_count;
  int                          blocks_pending;
  int                          cycle_count = 0;

  bitsliced_block_cipher_decrypt u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cipher_rows_low  (in_cipher_rows_low),
    .in_cipher_rows_high (in_cipher_rows_high),
    .out_valid           (out_valid),
    .out_plain_rows_low  (out_plain_rows_low),
    .out_plain_rows_high (out_plain_rows_high),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // watches both channels and the key writes, predicts and compares
  bbcd_plain_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cipher_rows_low  (in_cipher_rows_low),
    .in_cipher_rows_high (in_cipher_rows_high),
    .out_valid           (out_valid),
    .out_plain_rows_low  (out_plain_rows_low),
    .out_plain_rows_high (out_plain_rows_high),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatch_count      (mismatch_count),
    .blocks_pending      (blocks_pending)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the pipe hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic key_write(bbcd_pkg::key_reg_t idx, logic [63:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    key_write(bbcd_pkg::REG_KEY_W0_3, k0);
    key_write(bbcd_pkg::REG_KEY_W4_7, k1);
    key_write(bbcd_pkg::REG_KEY_W8_11, k2);
    key_write(bbcd_pkg::REG_KEY_W12_15, k3);
  endtask

  // present one item and hold it until the edge that takes it
  task automatic send_block(logic [63:0] lo, logic [63:0] hi);
    @(negedge clk);
    start               = 1'b1;
    in_cipher_rows_low  = lo;
    in_cipher_rows_high = hi;
    do @(posedge clk); while (busy);
  endtask

  // start low for a gap whose length is set by n, junk on the data lines meanwhile
  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      start               = 1'b0;
      in_cipher_rows_low  = {$urandom, $urandom};
      in_cipher_rows_high = {$urandom, $urandom};
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly no gap, some short ones, rarely a long one
  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      hold_off(0);
    else if (pick < 88) hold_off($urandom_range(1, 3));
    else if (pick < 98) hold_off($urandom_range(4, 12));
    else                hold_off($urandom_range(20, 60));
  endtask

  // pipe empty: every expected plaintext has come back
  task automatic wait_drained();
    hold_off(1);
    while (blocks_pending != 0) @(posedge clk);
  endtask

  // extreme and patterned blocks, reused under different keys
  task automatic send_edge_blocks();
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block('1, 64'h0);
    random_gap();
    send_block(64'h0, '1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    random_gap();
    // bits set or cleared at row ends, and byte and nibble patterns
    send_block(64'h0000_0000_0000_0001, 64'h0);
    send_block(64'h0, 64'h8000_0000_0000_0000);
    send_block(64'h8001_8001_8001_8001, 64'h8001_8001_8001_8001);
    send_block(64'h00FF_FF00_0F0F_F0F0, 64'hFFFF_0000_FFFF_0000);
    send_block(64'h7FFF_FFFF_FFFF_FFFE, 64'hFFFE_FFFF_FFFF_7FFF);
  endtask

  function automatic logic [63:0] rand_rows();
    int mode;
    mode = $urandom_range(0, 7);
    case (mode)
      0:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1:       return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random blocks, some phases back to back with no gaps at all
  task automatic send_random_blocks(int n);
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      send_block(rand_rows(), rand_rows());
      if (!no_gaps) random_gap();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_cipher_rows_low  = '0;
    in_cipher_rows_high = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // zero key straight out of reset
    send_edge_blocks();
    wait_drained();

    // all-ones key
    load_key('1, '1, '1, '1);
    send_edge_blocks();
    wait_drained();

    // only odd-round words set, then only even-round words
    load_key(64'h0, 64'h0, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_blocks(150);
    wait_drained();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, 64'h0, 64'h0);
    send_random_blocks(150);
    wait_drained();

    // checkerboard key
    load_key(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
             64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_random_blocks(100);
    wait_drained();

    // random keys
    repeat (7) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      send_random_blocks(185);
      wait_drained();
    end

    // back to zero key for a last pass
    load_key(64'h0, 64'h0, 64'h0, 64'h0);
    send_random_blocks(50);
    wait_drained();

    // give any stray result a chance to show up
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && blocks_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
